// File: design/imu_bcc_pkg.sv
`default_nettype none

package imu_bcc_pkg;

   localparam int DATA_W          = 16;
   localparam int WIDE_W          = 18;
   localparam int AXES            = 6;
   localparam int CSR_IDX_W       = 3;
   localparam int CAL_SAMPLES_DEF = 256;

   localparam logic signed [WIDE_W-1:0] GRAVITY_LSB = 18'sd4096;
   localparam logic signed [WIDE_W-1:0] SAT_MAX     = 18'sd32767;
   localparam logic signed [WIDE_W-1:0] SAT_MIN     = -18'sd32768;

   // lane order inside the datapath
   localparam int AXIS_AX = 0;
   localparam int AXIS_AY = 1;
   localparam int AXIS_AZ = 2;
   localparam int AXIS_GX = 3;
   localparam int AXIS_GY = 4;
   localparam int AXIS_GZ = 5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BIAS_VALID   = 3'd0,
      CSR_ACCEL_BIAS_X = 3'd1,
      CSR_ACCEL_BIAS_Y = 3'd2,
      CSR_ACCEL_BIAS_Z = 3'd3,
      CSR_GYRO_BIAS_X  = 3'd4,
      CSR_GYRO_BIAS_Y  = 3'd5,
      CSR_GYRO_BIAS_Z  = 3'd6
   } csr_index_type;

   // pipeline controls fanned out to every lane
   typedef struct packed {
      logic cal_take;   // calibration transaction accepted
      logic cal_last;   // it closes the calibration window
      logic s1_load;    // stage 1 captures a result-bearing transaction
      logic adv2;       // stage 1 -> stage 2
      logic adv3;       // stage 2 -> stage 3
   } lane_ctrl_type;

   function automatic logic signed [DATA_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[DATA_W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// File: design/imu_bcc_req_if.sv
`default_nettype none

interface imu_bcc_req_if import imu_bcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     kind;
   logic signed [DATA_W-1:0] raw_ax;
   logic signed [DATA_W-1:0] raw_ay;
   logic signed [DATA_W-1:0] raw_az;
   logic signed [DATA_W-1:0] raw_gx;
   logic signed [DATA_W-1:0] raw_gy;
   logic signed [DATA_W-1:0] raw_gz;

   modport source (output valid, kind, raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz,
                   input ready);
   modport sink   (input valid, kind, raw_ax, raw_ay, raw_az, raw_gx, raw_gy, raw_gz,
                   output ready);
endinterface

`default_nettype wire

// File: design/imu_bcc_rsp_if.sv
`default_nettype none

interface imu_bcc_rsp_if import imu_bcc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     is_bias;
   logic signed [DATA_W-1:0] out_ax;
   logic signed [DATA_W-1:0] out_ay;
   logic signed [DATA_W-1:0] out_az;
   logic signed [DATA_W-1:0] out_gx;
   logic signed [DATA_W-1:0] out_gy;
   logic signed [DATA_W-1:0] out_gz;

   modport source (output valid, is_bias, out_ax, out_ay, out_az, out_gx, out_gy, out_gz,
                   input ready);
   modport sink   (input valid, is_bias, out_ax, out_ay, out_az, out_gx, out_gy, out_gz,
                   output ready);
endinterface

`default_nettype wire

// File: design/imu_bcc_lane.sv
`default_nettype none

// One axis: bias subtract/saturate, running sum, and divide of the sum
// by the window length (reciprocal multiply, then one-step correction).
module imu_bcc_lane import imu_bcc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lane_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] raw,
   input  logic signed [DATA_W-1:0] bias,
   input  logic                     bias_en,
   output logic signed [DATA_W-1:0] comp,
   output logic signed [WIDE_W-1:0] mean
);

   localparam int SUM_W = DATA_W + $clog2(CAL_SAMPLES);
   localparam longint unsigned RECIP_L = (64'd1 << SUM_W) / CAL_SAMPLES;
   localparam logic [SUM_W:0]   RECIP = RECIP_L[SUM_W:0];
   localparam logic [SUM_W-1:0] DIV_N = SUM_W'(CAL_SAMPLES);

   logic signed [SUM_W-1:0] acc_ff;
   logic signed [SUM_W-1:0] total;
   logic        [SUM_W-1:0] mag;
   logic signed [WIDE_W-1:0] diff;
   logic signed [DATA_W-1:0] comp1;

   logic signed [DATA_W-1:0] s1_comp_ff, s2_comp_ff, s3_comp_ff;
   logic                     s1_sign_ff, s2_sign_ff, s3_sign_ff;
   logic        [SUM_W-1:0]  s1_mag_ff, s2_mag_ff, s3_mag_ff;
   logic        [SUM_W-1:0]  s2_q0_ff, s3_q0_ff, s3_qn_ff;

   logic [2*SUM_W:0]   recip_prod;
   logic [2*SUM_W-1:0] back_prod;
   logic [SUM_W-1:0]   rem;
   logic [SUM_W-1:0]   quot;
   logic signed [WIDE_W-1:0] quot_w;

   always_comb begin
      total = acc_ff + SUM_W'(raw);
      mag   = total[SUM_W-1] ? (~total + 1'b1) : total;
      diff  = WIDE_W'(raw) - (bias_en ? WIDE_W'(bias) : '0);
      comp1 = sat16(diff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (ctrl.cal_take) begin
         acc_ff <= ctrl.cal_last ? '0 : total;
      end
   end

   assign recip_prod = s1_mag_ff * RECIP;
   assign back_prod  = s2_q0_ff * DIV_N;

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         s1_comp_ff <= comp1;
         s1_sign_ff <= total[SUM_W-1];
         s1_mag_ff  <= mag;
      end
      if (ctrl.adv2) begin
         s2_comp_ff <= s1_comp_ff;
         s2_sign_ff <= s1_sign_ff;
         s2_mag_ff  <= s1_mag_ff;
         s2_q0_ff   <= recip_prod[2*SUM_W-1:SUM_W];
      end
      if (ctrl.adv3) begin
         s3_comp_ff <= s2_comp_ff;
         s3_sign_ff <= s2_sign_ff;
         s3_mag_ff  <= s2_mag_ff;
         s3_q0_ff   <= s2_q0_ff;
         s3_qn_ff   <= back_prod[SUM_W-1:0];
      end
   end

   // estimate is exact or one short; the remainder tells which
   always_comb begin
      rem    = s3_mag_ff - s3_qn_ff;
      quot   = s3_q0_ff + SUM_W'(rem >= DIV_N);
      quot_w = WIDE_W'(quot);
      mean   = s3_sign_ff ? -quot_w : quot_w;
      comp   = s3_comp_ff;
   end

endmodule

`default_nettype wire

// File: design/imu_bcc_merge.sv
`default_nettype none

// Window counter, stage valids and the output register that merges lanes.
module imu_bcc_merge import imu_bcc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   imu_bcc_req_if.sink              req_ch,
   imu_bcc_rsp_if.source            rsp_ch,
   output lane_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] comp [AXES],
   input  logic signed [WIDE_W-1:0] mean [AXES]
);

   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAL_SAMPLES - 1);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic v1_ff, v2_ff, v3_ff, ov_ff;
   logic v1_in, v2_in, v3_in, ov_in;
   logic b1_ff, b2_ff, b3_ff, ob_ff;
   logic signed [DATA_W-1:0] out_ff [AXES];
   logic signed [DATA_W-1:0] out_in [AXES];

   logic load_o, adv3, adv2, ready, take, last;

   always_comb begin
      load_o = v3_ff && (!ov_ff || rsp_ch.ready);
      adv3   = v2_ff && (!v3_ff || load_o);
      adv2   = v1_ff && (!v2_ff || adv3);
      ready  = !v1_ff || adv2;
      take   = req_ch.valid && ready;
      last   = (cnt_ff == LAST_CNT);

      ctrl.cal_take = take && req_ch.kind;
      ctrl.cal_last = last;
      ctrl.s1_load  = take && (!req_ch.kind || last);
      ctrl.adv2     = adv2;
      ctrl.adv3     = adv3;

      v1_in = ctrl.s1_load || (v1_ff && !adv2);
      v2_in = adv2 || (v2_ff && !adv3);
      v3_in = adv3 || (v3_ff && !load_o);
      ov_in = load_o || (ov_ff && !rsp_ch.ready);

      cnt_in = cnt_ff;
      if (ctrl.cal_take) begin
         cnt_in = last ? '0 : cnt_ff + 1'b1;
      end

      for (int i = 0; i < AXES; i++) begin
         if (b3_ff) begin
            out_in[i] = sat16(mean[i] - ((i == AXIS_AZ) ? GRAVITY_LSB : '0));
         end else begin
            out_in[i] = comp[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         ov_ff  <= 1'b0;
         b1_ff  <= 1'b0;
         b2_ff  <= 1'b0;
         b3_ff  <= 1'b0;
         ob_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         ov_ff  <= ov_in;
         if (ctrl.s1_load) b1_ff <= req_ch.kind;
         if (adv2)         b2_ff <= b1_ff;
         if (adv3)         b3_ff <= b2_ff;
         if (load_o)       ob_ff <= b3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load_o) begin
         out_ff <= out_in;
      end
   end

   assign req_ch.ready   = ready;
   assign rsp_ch.valid   = ov_ff;
   assign rsp_ch.is_bias = ob_ff;
   assign rsp_ch.out_ax  = out_ff[AXIS_AX];
   assign rsp_ch.out_ay  = out_ff[AXIS_AY];
   assign rsp_ch.out_az  = out_ff[AXIS_AZ];
   assign rsp_ch.out_gx  = out_ff[AXIS_GX];
   assign rsp_ch.out_gy  = out_ff[AXIS_GY];
   assign rsp_ch.out_gz  = out_ff[AXIS_GZ];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_CNT)
      else $error("calibration count past window");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (ctrl.cal_take && last) |=> (v1_ff && b1_ff && cnt_ff == '0))
      else $error("closing calibration transaction did not enter pipeline");

   a_comp_emits: assert property (@(posedge clock) disable iff (reset)
      (take && !req_ch.kind) |=> (v1_ff && !b1_ff))
      else $error("compensate transaction lost");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !load_o) |=> v3_ff)
      else $error("stage 3 dropped while stalled");

endmodule

`default_nettype wire

// File: design/imu_bias_calibrate_compensate_core.sv
`default_nettype none

// Channel   Dir  Handshake         Payload
// req_ch    in   valid/ready       kind, raw_ax..raw_gz (s16)
// rsp_ch    out  valid/ready       is_bias, out_ax..out_gz (s16)
// csr_*     in   csr_we only       csr_index (3b), csr_wdata (16b)
//
// One transaction per cycle sustained while rsp_ch is not stalled; a result passes
// the lane registers (input capture, reciprocal multiply, back multiply), then
// quotient correction, gravity offset and saturation feed the output register
// that drives rsp_ch.valid.
// Calibration transactions other than the window's last yield no result.
// Synchronous reset clears config, accumulators, window count and valids.
// req_ch.ready drops only when every stage is full and rsp_ch is stalled.
module imu_bias_calibrate_compensate_core import imu_bcc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   imu_bcc_req_if.sink          req_ch,
   imu_bcc_rsp_if.source        rsp_ch,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   logic                     bias_valid_ff;
   logic signed [DATA_W-1:0] bias_ff [AXES];

   logic signed [DATA_W-1:0] raw  [AXES];
   logic signed [DATA_W-1:0] comp [AXES];
   logic signed [WIDE_W-1:0] mean [AXES];
   lane_ctrl_type            ctrl;

   // config writes; unmapped index is ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         bias_valid_ff <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            bias_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            CSR_BIAS_VALID:   bias_valid_ff    <= csr_wdata[0];
            CSR_ACCEL_BIAS_X: bias_ff[AXIS_AX] <= csr_wdata;
            CSR_ACCEL_BIAS_Y: bias_ff[AXIS_AY] <= csr_wdata;
            CSR_ACCEL_BIAS_Z: bias_ff[AXIS_AZ] <= csr_wdata;
            CSR_GYRO_BIAS_X:  bias_ff[AXIS_GX] <= csr_wdata;
            CSR_GYRO_BIAS_Y:  bias_ff[AXIS_GY] <= csr_wdata;
            CSR_GYRO_BIAS_Z:  bias_ff[AXIS_GZ] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // fan the sample out to the lanes
   assign raw[AXIS_AX] = req_ch.raw_ax;
   assign raw[AXIS_AY] = req_ch.raw_ay;
   assign raw[AXIS_AZ] = req_ch.raw_az;
   assign raw[AXIS_GX] = req_ch.raw_gx;
   assign raw[AXIS_GY] = req_ch.raw_gy;
   assign raw[AXIS_GZ] = req_ch.raw_gz;

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      imu_bcc_lane #(
         .CAL_SAMPLES (CAL_SAMPLES)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .raw     (raw[g]),
         .bias    (bias_ff[g]),
         .bias_en (bias_valid_ff),
         .comp    (comp[g]),
         .mean    (mean[g])
      );
   end

   // window control, gravity offset, saturation and output register
   imu_bcc_merge #(
      .CAL_SAMPLES (CAL_SAMPLES)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .ctrl   (ctrl),
      .comp   (comp),
      .mean   (mean)
   );

endmodule

`default_nettype wire
